// ===== rtl/htlp_pkg.sv =====
// Package with shared types and codes for the linear-probe hash table.
`timescale 1ns / 1ps

package htlp_pkg;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_PREP,
      ST_PROBE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear;
      logic load_req;
      logic scan;
      logic probe_prep;
      logic probe;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic scan_done;
      logic mod_done;
      logic hit;
      logic is_insert;
      logic probe_done;
      logic out_free;
   } dp_sts_type;

endpackage

// ===== rtl/htlp_ctrl.sv =====
// Controller state machine that sequences clear, scan, probe and response steps.
`timescale 1ns / 1ps

module htlp_ctrl
   import htlp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_done && sts.mod_done) begin
               if (sts.hit || !sts.is_insert) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            if (sts.probe_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_PREP: begin
            cmd.probe_prep = 1'b1;
         end
         ST_PROBE: begin
            cmd.probe = 1'b1;
         end
         ST_FINISH: begin
            cmd.rsp_load = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== rtl/htlp_dp.sv =====
// Datapath with the slot memories, scan and probe pipeline, modulo unit and output register.
`timescale 1ns / 1ps

module htlp_dp
   import htlp_pkg::*;
#(
   parameter int SLOTS      = 16,
   parameter int KEY_BITS   = 16,
   parameter int VALUE_BITS = 16,
   localparam int CNT_W     = $clog2(SLOTS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_sts_type            sts,
   input  logic                  req_type,
   input  logic [KEY_BITS-1:0]   req_key,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  rsp_key_found,
   output logic [VALUE_BITS-1:0] rsp_found_value,
   output logic                  rsp_was_inserted,
   output logic                  rsp_table_full,
   output logic [CNT_W-1:0]      rsp_entry_count
);

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int NSTEP  = $clog2(KEY_BITS);
   localparam int SUM_W  = IDX_W + NSTEP;
   localparam int MCNT_W = $clog2(NSTEP + 2);
   localparam logic [SUM_W-1:0] DIV_TOP = SUM_W'(SLOTS) << (NSTEP - 1);

   function automatic int bit_weight(int pos);
      int w;
      w = 1;
      for (int i = 0; i < pos; i++) begin
         w = (2 * w) % SLOTS;
      end
      return w;
   endfunction

   logic [KEY_BITS-1:0]   key_mem [SLOTS];
   logic [VALUE_BITS-1:0] val_mem [SLOTS];
   logic                  vld_mem [SLOTS];

   logic [IDX_W-1:0]      clr_addr_ff, clr_addr_in;
   logic [CNT_W-1:0]      iss_cnt_ff, iss_cnt_in;
   logic [CNT_W-1:0]      chk_cnt_ff, chk_cnt_in;
   logic                  cmp_en_ff, cmp_en_in;
   logic                  hit_ff, hit_in;
   logic                  placed_ff, placed_in;
   logic [MCNT_W-1:0]     mod_cnt_ff, mod_cnt_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0]      addr_ff, addr_in;
   logic [IDX_W-1:0]      cmp_addr_ff, cmp_addr_in;
   logic                  type_ff, type_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [VALUE_BITS-1:0] hit_val_ff, hit_val_in;
   logic [SUM_W-1:0]      mod_acc_ff, mod_acc_in;
   logic [SUM_W-1:0]      mod_div_ff, mod_div_in;

   logic                  rsp_key_found_ff, rsp_key_found_in;
   logic [VALUE_BITS-1:0] rsp_found_value_ff, rsp_found_value_in;
   logic                  rsp_was_inserted_ff, rsp_was_inserted_in;
   logic                  rsp_table_full_ff, rsp_table_full_in;
   logic [CNT_W-1:0]      rsp_entry_count_ff, rsp_entry_count_in;

   logic [KEY_BITS-1:0]   rd_key_ff;
   logic [VALUE_BITS-1:0] rd_val_ff;
   logic                  rd_vld_ff;

   logic                  iss_en;
   logic                  ins_we;
   logic                  chk_all;
   logic [IDX_W-1:0]      wterm [KEY_BITS];
   logic [SUM_W-1:0]      mod_sum;

   assign iss_en  = (cmd.scan || cmd.probe) && (iss_cnt_ff != CNT_W'(SLOTS));
   assign ins_we  = cmd.probe && cmp_en_ff && !rd_vld_ff && !placed_ff;
   assign chk_all = (chk_cnt_ff == CNT_W'(SLOTS));

   // Each key bit contributes its power of two reduced modulo the slot count.
   for (genvar j = 0; j < KEY_BITS; j++) begin : g_weight
      localparam logic [IDX_W-1:0] WEIGHT = IDX_W'(bit_weight(j));
      assign wterm[j] = key_ff[j] ? WEIGHT : '0;
   end

   always_comb begin
      mod_sum = '0;
      for (int j = 0; j < KEY_BITS; j++) begin
         mod_sum = SUM_W'(mod_sum + SUM_W'(wterm[j]));
      end
   end

   // Slot memories: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         vld_mem[clr_addr_ff] <= 1'b0;
      end else if (ins_we) begin
         vld_mem[cmp_addr_ff] <= 1'b1;
         key_mem[cmp_addr_ff] <= key_ff;
         val_mem[cmp_addr_ff] <= val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (iss_en) begin
         rd_key_ff <= key_mem[addr_ff];
         rd_val_ff <= val_mem[addr_ff];
         rd_vld_ff <= vld_mem[addr_ff];
      end
   end

   always_comb begin
      clr_addr_in         = clr_addr_ff;
      iss_cnt_in          = iss_cnt_ff;
      chk_cnt_in          = chk_cnt_ff;
      cmp_en_in           = 1'b0;
      hit_in              = hit_ff;
      placed_in           = placed_ff;
      mod_cnt_in          = mod_cnt_ff;
      count_in            = count_ff;
      rsp_valid_in        = rsp_valid_ff;
      addr_in             = addr_ff;
      cmp_addr_in         = cmp_addr_ff;
      type_in             = type_ff;
      key_in              = key_ff;
      val_in              = val_ff;
      hit_val_in          = hit_val_ff;
      mod_acc_in          = mod_acc_ff;
      mod_div_in          = mod_div_ff;
      rsp_key_found_in    = rsp_key_found_ff;
      rsp_found_value_in  = rsp_found_value_ff;
      rsp_was_inserted_in = rsp_was_inserted_ff;
      rsp_table_full_in   = rsp_table_full_ff;
      rsp_entry_count_in  = rsp_entry_count_ff;

      if (cmd.clear) begin
         clr_addr_in = IDX_W'(clr_addr_ff + 1'b1);
      end

      // The weighted bit sum is loaded first, then reduced below the slot count by
      // subtracting halving multiples of it, one step per cycle.
      if (mod_cnt_ff == MCNT_W'(NSTEP + 1)) begin
         mod_acc_in = mod_sum;
         mod_div_in = DIV_TOP;
         mod_cnt_in = MCNT_W'(mod_cnt_ff - 1'b1);
      end else if (mod_cnt_ff != '0) begin
         if (mod_acc_ff >= mod_div_ff) begin
            mod_acc_in = mod_acc_ff - mod_div_ff;
         end
         mod_div_in = mod_div_ff >> 1;
         mod_cnt_in = MCNT_W'(mod_cnt_ff - 1'b1);
      end

      if (cmd.scan || cmd.probe) begin
         cmp_en_in = iss_en;
         if (iss_en) begin
            cmp_addr_in = addr_ff;
            iss_cnt_in  = CNT_W'(iss_cnt_ff + 1'b1);
            if (addr_ff == IDX_W'(SLOTS - 1)) begin
               addr_in = '0;
            end else begin
               addr_in = IDX_W'(addr_ff + 1'b1);
            end
         end
         if (cmp_en_ff) begin
            chk_cnt_in = CNT_W'(chk_cnt_ff + 1'b1);
         end
      end

      if (cmd.scan && cmp_en_ff && rd_vld_ff && (rd_key_ff == key_ff) && !hit_ff) begin
         hit_in     = 1'b1;
         hit_val_in = rd_val_ff;
      end

      if (ins_we) begin
         placed_in = 1'b1;
         count_in  = CNT_W'(count_ff + 1'b1);
      end

      if (cmd.load_req) begin
         type_in    = req_type;
         key_in     = req_key;
         val_in     = req_value;
         addr_in    = '0;
         iss_cnt_in = '0;
         chk_cnt_in = '0;
         hit_in     = 1'b0;
         placed_in  = 1'b0;
         mod_cnt_in = MCNT_W'(NSTEP + 1);
      end

      if (cmd.probe_prep) begin
         addr_in    = mod_acc_ff[IDX_W-1:0];
         iss_cnt_in = '0;
         chk_cnt_in = '0;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.rsp_load) begin
         rsp_valid_in        = 1'b1;
         rsp_key_found_in    = hit_ff;
         rsp_found_value_in  = (hit_ff && (type_ff == OP_LOOKUP)) ? hit_val_ff : '0;
         rsp_was_inserted_in = placed_ff;
         rsp_table_full_in   = (type_ff == OP_INSERT) && !hit_ff && !placed_ff;
         rsp_entry_count_in  = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         iss_cnt_ff   <= '0;
         chk_cnt_ff   <= '0;
         cmp_en_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         placed_ff    <= 1'b0;
         mod_cnt_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         iss_cnt_ff   <= iss_cnt_in;
         chk_cnt_ff   <= chk_cnt_in;
         cmp_en_ff    <= cmp_en_in;
         hit_ff       <= hit_in;
         placed_ff    <= placed_in;
         mod_cnt_ff   <= mod_cnt_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff             <= addr_in;
      cmp_addr_ff         <= cmp_addr_in;
      type_ff             <= type_in;
      key_ff              <= key_in;
      val_ff              <= val_in;
      hit_val_ff          <= hit_val_in;
      mod_acc_ff          <= mod_acc_in;
      mod_div_ff          <= mod_div_in;
      rsp_key_found_ff    <= rsp_key_found_in;
      rsp_found_value_ff  <= rsp_found_value_in;
      rsp_was_inserted_ff <= rsp_was_inserted_in;
      rsp_table_full_ff   <= rsp_table_full_in;
      rsp_entry_count_ff  <= rsp_entry_count_in;
   end

   always_comb begin
      sts            = '0;
      sts.clear_last = (clr_addr_ff == IDX_W'(SLOTS - 1));
      sts.scan_done  = chk_all;
      sts.mod_done   = (mod_cnt_ff == '0);
      sts.hit        = hit_ff;
      sts.is_insert  = (type_ff == OP_INSERT);
      sts.probe_done = placed_ff || chk_all;
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_key_found    = rsp_key_found_ff;
   assign rsp_found_value  = rsp_found_value_ff;
   assign rsp_was_inserted = rsp_was_inserted_ff;
   assign rsp_table_full   = rsp_table_full_ff;
   assign rsp_entry_count  = rsp_entry_count_ff;

endmodule

// ===== rtl/hash_table_linear_probe.sv =====
// Top level of the open-addressing hash table with linear probing.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_ready  req_type, req_key, req_value
//   rsp      out        rsp_valid/rsp_ready  rsp_key_found, rsp_found_value,
//                                            rsp_was_inserted, rsp_table_full,
//                                            rsp_entry_count
//
// A lookup scans every slot and an insert that finds no match then probes on from its hash slot,
// reading every slot through the single read port of the slot memory, one per cycle.
// After reset a clearing pass marks every slot free before req_ready rises.
// A finished result sits in the output register while the next transfer on req is taken.
// If that register is still full when the next result is done, the block holds until it drains.
`timescale 1ns / 1ps

module hash_table_linear_probe
   import htlp_pkg::*;
#(
   parameter int SLOTS      = 16,
   parameter int KEY_BITS   = 16,
   parameter int VALUE_BITS = 16,
   localparam int CNT_W     = $clog2(SLOTS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_type,
   input  logic [KEY_BITS-1:0]   req_key,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_key_found,
   output logic [VALUE_BITS-1:0] rsp_found_value,
   output logic                  rsp_was_inserted,
   output logic                  rsp_table_full,
   output logic [CNT_W-1:0]      rsp_entry_count
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   htlp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   htlp_dp #(
      .SLOTS      (SLOTS),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_type         (req_type),
      .req_key          (req_key),
      .req_value        (req_value),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_key_found    (rsp_key_found),
      .rsp_found_value  (rsp_found_value),
      .rsp_was_inserted (rsp_was_inserted),
      .rsp_table_full   (rsp_table_full),
      .rsp_entry_count  (rsp_entry_count)
   );

   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_was_inserted && rsp_table_full)
                    && !(rsp_key_found && (rsp_was_inserted || rsp_table_full)))
      else $error("response reports more than one outcome");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= CNT_W'(SLOTS)))
      else $error("entry count exceeds the slot count");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_key_found) |-> (rsp_found_value == '0))
      else $error("found value is nonzero on a miss");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is in progress");

endmodule
